/* rtl/core/adfx_pkg.sv */
// shared types, constants and helpers for the ascii decimal to fixed point block
`timescale 1ns / 1ps

package adfx_pkg;

    localparam int FRAC_BITS   = 16;
    localparam int FRAC_DIGITS = 9;
    localparam int INT_BITS    = 31;

    localparam int VALUE_W = 48;
    localparam int FRAC_W  = 30;
    localparam int DIGIT_W = 4;
    localparam int CNT_W   = $clog2(FRAC_BITS + 1);

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;

    typedef enum logic [1:0] {
        PH_SKIP = 2'd0,
        PH_INT  = 2'd1,
        PH_FRAC = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        ST_PARSE = 2'd0,
        ST_DIV   = 2'd1,
        ST_LOAD  = 2'd2
    } state_t;

    typedef struct packed {
        logic                negative;
        logic [INT_BITS-1:0] int_mag;
        logic [FRAC_W-1:0]   frac_val;
        logic [DIGIT_W-1:0]  frac_cnt;
        logic                sat;
    } num_t;

    function automatic logic [FRAC_W-1:0] pow10(input logic [DIGIT_W-1:0] k);
        logic [FRAC_W-1:0] p;
        begin
            case (k)
                4'd0:    p = 30'd1;
                4'd1:    p = 30'd10;
                4'd2:    p = 30'd100;
                4'd3:    p = 30'd1000;
                4'd4:    p = 30'd10000;
                4'd5:    p = 30'd100000;
                4'd6:    p = 30'd1000000;
                4'd7:    p = 30'd10000000;
                4'd8:    p = 30'd100000000;
                4'd9:    p = 30'd1000000000;
                default: p = 30'd1;
            endcase
            return p;
        end
    endfunction

endpackage

/* rtl/core/adfx_parser.sv */
// character classifier and digit accumulators
`timescale 1ns / 1ps

module adfx_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           char_code,
    output logic                 finish,
    output adfx_pkg::num_t       num
);
    import adfx_pkg::*;

    phase_t              phase_reg, phase_next;
    logic                neg_reg, neg_next;
    logic [INT_BITS-1:0] int_reg, int_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [DIGIT_W-1:0]  cnt_reg, cnt_next;
    logic                sat_reg, sat_next;

    logic                is_digit;
    logic                is_ws;
    logic [3:0]          digit;
    logic [INT_BITS+3:0] int_sum;
    logic [FRAC_W+3:0]   frac_sum;
    logic                int_ovf;

    assign is_digit = (char_code inside {[CH_ZERO:CH_NINE]});
    assign is_ws    = (char_code inside {CH_BLANK, CH_TAB, CH_CR, CH_LF});
    assign digit    = 4'(char_code - CH_ZERO);

    assign int_sum  = {1'b0, int_reg, 3'b000} + {3'b000, int_reg, 1'b0}
                    + {(INT_BITS)'(0), digit};
    assign int_ovf  = (int_sum[INT_BITS+3:INT_BITS] != 4'd0);
    assign frac_sum = {1'b0, frac_reg, 3'b000} + {3'b000, frac_reg, 1'b0}
                    + {(FRAC_W)'(0), digit};

    // phase sequencing
    always_comb
    begin
        phase_next = phase_reg;
        finish     = 1'b0;
        if (accept)
        begin
            case (phase_reg)
                PH_INT:
                begin
                    if (!is_digit && char_code == CH_POINT)
                        phase_next = PH_FRAC;
                    else if (!is_digit)
                        finish = 1'b1;
                end
                PH_FRAC:
                begin
                    if (!is_digit)
                        finish = 1'b1;
                end
                default:
                begin
                    phase_next = PH_SKIP;
                    if (is_ws)
                        phase_next = PH_SKIP;
                    else if (char_code == CH_MINUS || is_digit)
                        phase_next = PH_INT;
                    else if (char_code == CH_POINT)
                        phase_next = PH_FRAC;
                    else
                        finish = 1'b1;
                end
            endcase
            if (finish)
                phase_next = PH_SKIP;
        end
    end

    // accumulators
    always_comb
    begin
        neg_next  = neg_reg;
        int_next  = int_reg;
        frac_next = frac_reg;
        cnt_next  = cnt_reg;
        sat_next  = sat_reg;
        if (accept && finish)
        begin
            neg_next  = 1'b0;
            int_next  = '0;
            frac_next = '0;
            cnt_next  = '0;
            sat_next  = 1'b0;
        end
        else if (accept && is_digit && phase_reg == PH_FRAC)
        begin
            if (cnt_reg < DIGIT_W'(FRAC_DIGITS))
            begin
                frac_next = frac_sum[FRAC_W-1:0];
                cnt_next  = cnt_reg + 4'd1;
            end
        end
        else if (accept && is_digit)
        begin
            if (int_ovf)
            begin
                int_next = '1;
                sat_next = 1'b1;
            end
            else
                int_next = int_sum[INT_BITS-1:0];
        end
        else if (accept && char_code == CH_MINUS && phase_reg != PH_INT)
            neg_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            neg_reg   <= 1'b0;
            int_reg   <= '0;
            frac_reg  <= '0;
            cnt_reg   <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            neg_reg   <= neg_next;
            int_reg   <= int_next;
            frac_reg  <= frac_next;
            cnt_reg   <= cnt_next;
            sat_reg   <= sat_next;
        end
    end

    assign num.negative = neg_reg;
    assign num.int_mag  = int_reg;
    assign num.frac_val = frac_reg;
    assign num.frac_cnt = cnt_reg;
    assign num.sat      = sat_reg;

endmodule

/* rtl/core/adfx_divider.sv */
// restoring divider, one quotient bit per cycle, for the fraction scaling
`timescale 1ns / 1ps

module adfx_divider (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [adfx_pkg::FRAC_W-1:0]     frac_val,
    input  logic [adfx_pkg::DIGIT_W-1:0]    frac_cnt,
    output logic                            busy,
    output logic [adfx_pkg::FRAC_BITS-1:0]  quotient
);
    import adfx_pkg::*;

    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [FRAC_W-1:0]    rem_reg, rem_next;
    logic [FRAC_W-1:0]    den_reg, den_next;
    logic [FRAC_BITS-1:0] quo_reg, quo_next;

    logic [FRAC_W:0]      shifted;
    logic [FRAC_W:0]      diff;
    logic                 fits;

    // shared compare and subtract
    assign shifted = {rem_reg, 1'b0};
    assign diff    = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(FRAC_BITS);
            rem_next  = frac_val;
            den_next  = pow10(frac_cnt);
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[FRAC_W-1:0] : shifted[FRAC_W-1:0];
            quo_next = {quo_reg[FRAC_BITS-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/ascii_decimal_to_fixed_point.sv */
// top level: ascii decimal text stream to signed q.16 fixed point
//
// slave channel s_axis takes one ascii character per transfer in tdata[7:0].
// master channel m_axis gives one parsed number per transfer: tdata holds
// the 48-bit two's complement value with 16 fraction bits, tuser[0] is set
// when the integer part was clamped.
// whitespace, sign, digits and point are taken at one character per cycle.
// the character that ends a number is consumed; after it the fraction is
// scaled by a restoring divider giving one quotient bit per cycle (16 divide
// steps), then the block waits to see the divider idle and loads the number
// into the output register for m_axis; s_axis tready is low from the divide
// start until that load.
// the result sits in an output register; if the receiver stalls, parsing of
// the next number continues and only its final load waits for the register
// to empty.
// reset clears the parse state and drops m_axis tvalid; the block then skips
// leading whitespace of the next number.
`timescale 1ns / 1ps

module ascii_decimal_to_fixed_point (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // char_code
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // value
    output logic [0:0]  m_axis_tuser    // saturated
);
    import adfx_pkg::*;

    state_t               state_reg, state_next;
    logic                 accept;
    logic                 finish;
    num_t                 num;
    logic                 div_start;
    logic                 div_busy;
    logic [FRAC_BITS-1:0] quotient;
    logic                 load;

    logic                 neg_reg;
    logic [INT_BITS-1:0]  int_reg;
    logic                 sat_reg;

    logic                 out_valid_reg, out_valid_next;
    logic [VALUE_W-1:0]   value_reg;
    logic                 osat_reg;

    logic [VALUE_W-1:0]   mag;

    assign accept = s_axis_tvalid && s_axis_tready;

    adfx_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .char_code (s_axis_tdata),
        .finish    (finish),
        .num       (num)
    );

    adfx_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .frac_val (num.frac_val),
        .frac_cnt (num.frac_cnt),
        .busy     (div_busy),
        .quotient (quotient)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_PARSE:
            begin
                if (finish)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (!div_busy)
                    state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (!out_valid_reg || m_axis_tready)
                    state_next = ST_PARSE;
            end
            default: state_next = ST_PARSE;
        endcase
    end

    // outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        div_start     = 1'b0;
        load          = 1'b0;
        case (state_reg)
            ST_PARSE:
            begin
                s_axis_tready = 1'b1;
                div_start     = finish;
            end
            ST_LOAD:
                load = !out_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    assign mag = VALUE_W'({int_reg, quotient});

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_PARSE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            neg_reg <= num.negative;
            int_reg <= num.int_mag;
            sat_reg <= num.sat;
        end
        if (load)
        begin
            value_reg <= neg_reg ? (VALUE_W'(0) - mag) : mag;
            osat_reg  <= sat_reg;
        end
    end

    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = value_reg;
    assign m_axis_tuser[0] = osat_reg;

`ifndef ASSERT_OFF
    a_busy_in_div : assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> state_reg == ST_DIV)
        else $error("divider busy outside divide state");

    a_no_input_in_div : assert property (@(posedge clk) disable iff (!rst_n)
        div_busy |-> !s_axis_tready)
        else $error("input taken while dividing");

    a_finish_starts : assert property (@(posedge clk) disable iff (!rst_n)
        finish |=> div_busy && state_reg == ST_DIV)
        else $error("terminating character did not start the divider");

    a_load_fills : assert property (@(posedge clk) disable iff (!rst_n)
        load |=> m_axis_tvalid && state_reg == ST_PARSE)
        else $error("load did not fill the output register");
`endif

endmodule

/* dv/adfx_checker.sv */
// checker for the ascii decimal to fixed point block: predicts parsed numbers and compares them
`timescale 1ns / 1ps

module adfx_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [47:0] m_axis_tdata,
    input  logic [0:0]  m_axis_tuser,
    output int          errors,
    output int          pending
);
    import adfx_pkg::*;

    typedef struct {
        logic [47:0] value;
        logic        saturated;
    } number_t;

    localparam logic [63:0] INT_LIMIT = (64'd1 << INT_BITS) - 64'd1;

    number_t     expected_numbers[$];
    phase_t      phase;
    logic        negative;
    logic [63:0] int_mag;
    logic [63:0] frac_val;
    int          frac_cnt;
    logic        sat;
    int          mismatches;

    function void clear_number();
        phase    = PH_SKIP;
        negative = 1'b0;
        int_mag  = 64'd0;
        frac_val = 64'd0;
        frac_cnt = 0;
        sat      = 1'b0;
    endfunction

    function void add_int_digit(input logic [7:0] c);
        logic [63:0] grown;
        grown = int_mag * 64'd10 + 64'(c - CH_ZERO);
        if (grown > INT_LIMIT)
        begin
            int_mag = INT_LIMIT;
            sat     = 1'b1;
        end
        else
        begin
            int_mag = grown;
        end
    endfunction

    function void close_number();
        logic [63:0] divisor;
        logic [63:0] mag;
        number_t     num;
        divisor = 64'd1;
        repeat (frac_cnt) divisor = divisor * 64'd10;
        mag = (int_mag << FRAC_BITS) + ((frac_val << FRAC_BITS) / divisor);
        if (negative)
            mag = 64'd0 - mag;
        num.value     = mag[47:0];
        num.saturated = sat;
        expected_numbers.push_back(num);
        clear_number();
    endfunction

    function void parse_char(input logic [7:0] c);
        logic is_digit;
        logic is_blank;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        is_blank = (c == CH_BLANK) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
        case (phase)
            PH_INT:
            begin
                if (is_digit)
                    add_int_digit(c);
                else if (c == CH_POINT)
                    phase = PH_FRAC;
                else
                    close_number();
            end
            PH_FRAC:
            begin
                if (is_digit)
                begin
                    if (frac_cnt < FRAC_DIGITS && frac_cnt < 9)
                    begin
                        frac_val = frac_val * 64'd10 + 64'(c - CH_ZERO);
                        frac_cnt = frac_cnt + 1;
                    end
                end
                else
                begin
                    close_number();
                end
            end
            default:
            begin
                phase = PH_SKIP;
                if (is_blank)
                begin
                end
                else if (c == CH_MINUS)
                begin
                    negative = 1'b1;
                    phase    = PH_INT;
                end
                else if (is_digit)
                begin
                    add_int_digit(c);
                    phase = PH_INT;
                end
                else if (c == CH_POINT)
                begin
                    phase = PH_FRAC;
                end
                else
                begin
                    close_number();
                end
            end
        endcase
    endfunction

    task automatic check_number();
        number_t want;
        if (expected_numbers.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result transfer: value %h saturated %b",
                         m_axis_tdata, m_axis_tuser[0]);
        end
        else
        begin
            want = expected_numbers.pop_front();
            if (want.value !== m_axis_tdata || want.saturated !== m_axis_tuser[0])
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: expected value %h saturated %b,",
                              " got value %h saturated %b"},
                             want.value, want.saturated, m_axis_tdata, m_axis_tuser[0]);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_number();
            expected_numbers.delete();
            mismatches = 0;
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_number();
            if (s_axis_tvalid && s_axis_tready)
                parse_char(s_axis_tdata);
            errors  <= mismatches;
            pending <= expected_numbers.size();
        end
    end

endmodule

/* dv/tb_ascii_decimal_to_fixed_point.sv */
// testbench top for the ascii decimal to fixed point block: character stimulus and verdict
`timescale 1ns / 1ps

module tb_ascii_decimal_to_fixed_point;

    import adfx_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;     // char_code
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;     // value
    logic [0:0]  m_axis_tuser;     // saturated
    int          errors;
    int          pending;
    bit          quiet;
    int          ready_hold = 0;
    int          stall_draw;
    int          random_chars;

    ascii_decimal_to_fixed_point dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    adfx_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .errors        (errors),
        .pending       (pending)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver may stall after a result transfer, at random and never while quiet
    always @(posedge clk)
    begin
        if (m_axis_tvalid && m_axis_tready)
        begin
            stall_draw = quiet ? 0 : $urandom_range(0, 5);
            ready_hold    <= stall_draw;
            m_axis_tready <= (stall_draw == 0);
        end
        else if (ready_hold != 0)
        begin
            ready_hold    <= ready_hold - 1;
            m_axis_tready <= (ready_hold == 1);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic send_char(input logic [7:0] c);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        repeat (gap)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        random_chars++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_char(s[i]);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending != 0);
    endtask

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return CH_BLANK;
            1:       return CH_TAB;
            2:       return CH_CR;
            default: return CH_LF;
        endcase
    endfunction

    function automatic logic [7:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(0, 9));
    endfunction

    task automatic send_random_number();
        int mode;
        int n_int;
        int n_frac;
        mode = $urandom_range(0, 19);
        repeat ($urandom_range(0, 3)) send_char(pick_blank());
        if (mode < 2)
        begin
            send_char(8'($urandom_range(0, 255)));
        end
        else if (mode < 4)
        begin
            repeat ($urandom_range(1, 4))
            begin
                case ($urandom_range(0, 3))
                    0:       send_char(CH_MINUS);
                    1:       send_char(CH_POINT);
                    2:       send_char(pick_digit());
                    default: send_char(8'($urandom_range(0, 255)));
                endcase
            end
        end
        else
        begin
            if ($urandom_range(0, 4) < 2)
                send_char(CH_MINUS);
            n_int = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 12) : $urandom_range(0, 6);
            repeat (n_int) send_char(pick_digit());
            if ($urandom_range(0, 4) < 3)
            begin
                send_char(CH_POINT);
                n_frac = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 12)
                                                     : $urandom_range(0, 5);
                repeat (n_frac) send_char(pick_digit());
            end
            case ($urandom_range(0, 3))
                0:       send_char(pick_blank());
                1:       send_char(8'h2C);
                2:       send_char(8'h3B);
                default: send_char(8'($urandom_range(0, 255)));
            endcase
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        quiet         = 1'b0;
        random_chars  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_char(CH_BLANK);
        send_char(CH_TAB);
        send_char(CH_CR);
        send_char(CH_LF);
        send_text("7 0 -0 ");
        send_text("2147483647 2147483648 -99999999999 ");
        send_text("1.5 -.25;. - x");
        send_text("1.2.3 12-3 --5 ");
        send_text("3.14159265358979 0.999999999 -2147483647.999999999 ");
        send_char(8'hFF);
        send_char(8'h00);
        send_text("5a");
        wait_drained();

        random_chars = 0;
        while (random_chars < 1200)
        begin
            if ($urandom_range(0, 7) == 0)
                quiet = ~quiet;
            send_random_number();
        end
        send_char(CH_BLANK);
        wait_drained();
        repeat (40) @(posedge clk);

        if (errors == 0 && pending == 0)
            $display("ascii_decimal_to_fixed_point regression: pass");
        else
            $display("ascii_decimal_to_fixed_point regression: fail");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("ascii_decimal_to_fixed_point regression: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/core/adfx_pkg.sv
rtl/core/adfx_parser.sv
rtl/core/adfx_divider.sv
rtl/core/ascii_decimal_to_fixed_point.sv
dv/adfx_checker.sv
dv/tb_ascii_decimal_to_fixed_point.sv
